[hw/rtl/qcst_pkg.sv]
// Package for the queued clocked serial transmitter.
// Holds the queue sizing constants, item codes and the command and result records.
// Depends on nothing; the front, command queue, engine and top level import it.
package qcst_pkg;

	// Byte queue sizing.
	localparam int QUEUE_DEPTH = 16;
	localparam int QAW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

	// Item kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// Bit counter marker for "no word loaded", and word size limits.
	localparam logic [3:0] IDLE_INDEX       = 4'd15;
	localparam logic [3:0] FRAME_BITS_RESET = 4'd8;
	localparam logic [3:0] FRAME_BITS_MIN   = 4'd1;
	localparam logic [3:0] FRAME_BITS_MAX   = 4'd8;

	// One classified command on its way from the front to the engine.
	typedef struct packed {
		logic       is_tick;
		logic [7:0] data_byte;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic clock_level;
		logic data_level;
		logic lines_updated;
		logic status;
		logic queue_empty;
		logic word_in_progress;
	} result_t;

	// Clamp the programmed word size into the range one to eight.
	function automatic logic [3:0] eff_size(input logic [3:0] ws);
		logic [3:0] r;
		r = ws;
		if (ws == 4'd0) begin
			r = FRAME_BITS_MIN;
		end else if (ws > FRAME_BITS_MAX) begin
			r = FRAME_BITS_MAX;
		end
		return r;
	endfunction

endpackage

[hw/rtl/qcst_if.sv]
// Handshake channels of the queued clocked serial transmitter.
// One interface for incoming words and one for result words; no dependencies.

// Incoming word: a byte write or a transmit tick.
interface qcst_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// Result word: line levels and queue status after one incoming word.
interface qcst_result_if;
	logic valid;
	logic ready;
	logic clock_level;
	logic data_level;
	logic lines_updated;
	logic status;
	logic queue_empty;
	logic word_in_progress;

	modport source (output valid, output clock_level, output data_level,
		output lines_updated, output status, output queue_empty,
		output word_in_progress, input ready);
	modport sink   (input valid, input clock_level, input data_level,
		input lines_updated, input status, input queue_empty,
		input word_in_progress, output ready);
endinterface

[hw/rtl/qcst_front.sv]
// Front stage: accepts incoming words, classifies them and registers the command.
// Depends on qcst_pkg and qcst_item_if.
module qcst_front
	import qcst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	qcst_item_if.sink  item,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_ready
);

	logic valid_s1;
	cmd_t cmd_s1;

	// The stage takes a new word whenever it is empty or hands its word on.
	assign item.ready = !valid_s1 || cmd_ready;
	assign cmd_valid  = valid_s1;
	assign cmd        = cmd_s1;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// Classified command; a tick carries no byte.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1.is_tick   <= (item.kind == KIND_TICK);
			cmd_s1.data_byte <= (item.kind == KIND_TICK) ? 8'd0 : item.data_byte;
		end
	end

endmodule

[hw/rtl/qcst_cmd_queue.sv]
// Two-entry command queue between the front stage and the engine.
// Depends on qcst_pkg for the command record.
module qcst_cmd_queue
	import qcst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  cmd_t push_cmd,
	output logic push_ready,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop_ready
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[hw/rtl/qcst_engine.sv]
// Back end: byte queue, shift register, line drivers and the result register.
// Holds the word size register. Depends on qcst_pkg and qcst_result_if.
module qcst_engine
	import qcst_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	input  cmd_t         cmd,
	output logic         cmd_ready,
	input  logic         frame_bits_we,
	input  logic [3:0]   frame_bits_data,
	qcst_result_if.source result
);

	logic [7:0]     store_q [QUEUE_DEPTH];
	logic [QAW-1:0] head_q;
	logic [QAW-1:0] tail_q;
	logic [QCW-1:0] count_q;
	logic [7:0]     shift_q;
	logic [3:0]     bit_idx_q;
	logic           clk_line_q;
	logic           data_line_q;
	logic [3:0]     frame_bits_q;
	logic           out_valid_q;
	result_t        out_q;

	logic           take;
	logic [3:0]     size;
	logic           q_full;
	logic           q_empty;
	logic           do_write;
	logic           need_load;
	logic           do_shift;
	logic           do_load;
	logic [7:0]     word;
	logic [3:0]     idx;
	logic [QAW-1:0] head_nx;
	logic [QAW-1:0] tail_nx;
	logic [QCW-1:0] count_nx;
	logic [3:0]     bit_idx_nx;
	logic           clk_line_nx;
	logic           data_line_nx;

	// A command executes whenever the result register is free or being drained.
	assign cmd_ready = !out_valid_q || result.ready;
	assign take      = cmd_valid && cmd_ready;
	assign size      = eff_size(frame_bits_q);
	assign q_full    = (count_q == QCW'(QUEUE_DEPTH));
	assign q_empty   = (count_q == '0);

	// Decode the command against the current queue and bit counter.
	always_comb begin
		do_write     = take && !cmd.is_tick && !q_full;
		need_load    = (bit_idx_q >= size);
		do_shift     = take && cmd.is_tick && !(need_load && q_empty);
		do_load      = do_shift && need_load;
		word         = need_load ? store_q[head_q] : shift_q;
		idx          = need_load ? 4'd0 : bit_idx_q;
		head_nx      = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_nx      = (tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
		count_nx     = count_q;
		if (do_write) begin
			count_nx = count_q + 1'b1;
		end else if (do_load) begin
			count_nx = count_q - 1'b1;
		end
		bit_idx_nx   = do_shift ? idx + 4'd1 : bit_idx_q;
		clk_line_nx  = do_shift ? !clk_line_q : clk_line_q;
		data_line_nx = do_shift ? word[idx[2:0]] : data_line_q;
	end

	// Queue pointers, bit counter, line levels and word size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			shift_q      <= 8'd0;
			bit_idx_q    <= IDLE_INDEX;
			clk_line_q   <= 1'b0;
			data_line_q  <= 1'b0;
			frame_bits_q <= FRAME_BITS_RESET;
		end else begin
			if (frame_bits_we) begin
				frame_bits_q <= frame_bits_data;
			end
			if (do_write) begin
				tail_q <= tail_nx;
			end
			if (do_load) begin
				head_q  <= head_nx;
				shift_q <= word;
			end
			count_q     <= count_nx;
			bit_idx_q   <= bit_idx_nx;
			clk_line_q  <= clk_line_nx;
			data_line_q <= data_line_nx;
		end
	end

	// Byte storage; entries are only read once written.
	always_ff @(posedge clk) begin
		if (do_write) begin
			store_q[tail_q] <= cmd.data_byte;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_ready) begin
			out_valid_q <= cmd_valid;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.clock_level      <= clk_line_nx;
			out_q.data_level       <= data_line_nx;
			out_q.lines_updated    <= do_shift;
			out_q.status           <= !cmd.is_tick && q_full;
			out_q.queue_empty      <= (count_nx == '0);
			out_q.word_in_progress <= (bit_idx_nx < size);
		end
	end

	assign result.valid            = out_valid_q;
	assign result.clock_level      = out_q.clock_level;
	assign result.data_level       = out_q.data_level;
	assign result.lines_updated    = out_q.lines_updated;
	assign result.status           = out_q.status;
	assign result.queue_empty      = out_q.queue_empty;
	assign result.word_in_progress = out_q.word_in_progress;

endmodule

[hw/rtl/queued_clocked_serial_transmitter.sv]
// Top level of the queued clocked serial transmitter.
// Depends on qcst_pkg, qcst_if, qcst_front, qcst_cmd_queue and qcst_engine.
//
// Channel    Dir  Handshake        Payload
// item       in   valid / ready    kind, data_byte
// result     out  valid / ready    clock_level, data_level, lines_updated,
//                                  status, queue_empty, word_in_progress
// frame_bits in   write enable     frame_bits_data (4 bits)
//
// One word is taken per cycle while the front register is empty or hands its word
// on; its result is registered in the front register, the command queue and the
// engine result register before it is offered. The engine executes one
// command per cycle against the byte queue and shifter while not stalled.
// A stalled result stops the engine; the two-entry command queue and the front
// register keep taking words until they fill. Reset is asynchronous, active
// low, and leaves the byte queue empty, lines low and word size eight.
module queued_clocked_serial_transmitter
	import qcst_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	qcst_item_if.sink     item,
	qcst_result_if.source result,
	input  logic          frame_bits_we,
	input  logic [3:0]    frame_bits_data
);

	logic fr_valid;
	cmd_t fr_cmd;
	logic fr_ready;
	logic eng_valid;
	cmd_t eng_cmd;
	logic eng_ready;

	// Front: accept and classify.
	qcst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd_valid (fr_valid),
		.cmd       (fr_cmd),
		.cmd_ready (fr_ready)
	);

	// Decoupling queue between front and engine.
	qcst_cmd_queue u_cmd_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_cmd   (fr_cmd),
		.push_ready (fr_ready),
		.pop_valid  (eng_valid),
		.pop_cmd    (eng_cmd),
		.pop_ready  (eng_ready)
	);

	// Engine: byte queue, shifter and results.
	qcst_engine u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (eng_valid),
		.cmd             (eng_cmd),
		.cmd_ready       (eng_ready),
		.frame_bits_we   (frame_bits_we),
		.frame_bits_data (frame_bits_data),
		.result          (result)
	);

endmodule

[hw/rtl/qcst_checker.sv]
// Port-level checker for the queued clocked serial transmitter, bound to the top.
// Depends on the top level's ports only.
module qcst_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic clock_level,
	input logic data_level,
	input logic lines_updated,
	input logic status,
	input logic queue_empty
);

	// A result that is not taken stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its line levels.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(clock_level) && $stable(data_level))
		else $error("result payload changed while stalled");

	// A tick that drives the lines never reports a dropped byte.
	a_tick_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(lines_updated && status))
		else $error("lines updated and overflow in one result");

	// An overflow means the queue is full, so it cannot be empty.
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status |-> !queue_empty)
		else $error("overflow reported with an empty queue");

endmodule

bind queued_clocked_serial_transmitter qcst_checker u_qcst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.clock_level   (result.clock_level),
	.data_level    (result.data_level),
	.lines_updated (result.lines_updated),
	.status        (result.status),
	.queue_empty   (result.queue_empty)
);
